// File: design/cke_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_pkg
// Types, constants and helpers shared by the car kinematic Euler step block.
// ----------------------------------------------------------------------------
package cke_pkg;

  // Integration step in Q16.16.
  localparam logic signed [17:0] TIME_STEP_Q16 = 18'sd6554;

  // Angles in Q2.30.
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_TWO_PI  = 34'sd6746518852;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
  localparam logic [33:0]        TWO_PI_U    = 34'd6746518852;
  localparam logic [46:0]        TWO_PI_U47  = 47'd6746518852;
  // floor(2^16 / 2pi): estimates the turn count of a Q16.16 angle.
  localparam logic [13:0]        RECIP_TWO_PI = 14'd10430;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Pipeline depths of the fixed sections.
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = 33;
  localparam int BACK_LAT  = 4;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_MAX_SPEED     = 2'd0;
  localparam logic [1:0] CFG_MAX_STEER     = 2'd1;
  localparam logic [1:0] CFG_INV_WHEELBASE = 2'd2;
  localparam logic [30:0] MAX_SPEED_RST     = 31'd655360;
  localparam logic [16:0] MAX_STEER_RST     = 17'd34315;
  localparam logic [30:0] INV_WHEELBASE_RST = 31'd65536;

  typedef struct packed {
    logic               flip;
    logic signed [33:0] z;
  } angle_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] th;
    logic signed [31:0] nv;
    logic signed [31:0] ns;
    logic               ok;
    logic signed [31:0] w1;
  } side_t;

  typedef struct packed {
    side_t  side;
    angle_t ah;
    angle_t as;
  } front_t;

  typedef struct packed {
    side_t              side;
    logic signed [31:0] cv;
    logic signed [31:0] sv;
  } mid_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007FFFFFFF) r = S32_MAX;
    else if (v < 64'shFFFFFFFF80000000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // Folds an angle in [-pi, pi] into [-pi/2, pi/2]; flip marks a shift by pi.
  function automatic angle_t half_reduce(input logic signed [33:0] z);
    angle_t r;
    r.flip = 1'b0;
    r.z    = z;
    if (z > Q30_HALF_PI) begin
      r.z    = z - Q30_PI;
      r.flip = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      r.z    = z + Q30_PI;
      r.flip = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/cke_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_delay
// Enabled shift line that carries side data alongside a pipelined unit.
// ----------------------------------------------------------------------------
module cke_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] pipe [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= din;
      for (int i = 1; i < DEPTH; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign dout = pipe[DEPTH-1];

endmodule
`default_nettype wire

// File: design/cke_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_front
// Five-stage front end: speed and steering integration and clamping, heading
// reduction to [-pi/2, pi/2], and the speed-over-wheelbase product.
// ----------------------------------------------------------------------------
module cke_front (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  heading,
  input  logic signed [31:0]  speed,
  input  logic signed [31:0]  steer_angle,
  input  logic signed [31:0]  speed_rate,
  input  logic signed [31:0]  steer_rate,
  input  logic [30:0]         max_speed,
  input  logic [16:0]         max_steer,
  input  logic [30:0]         inv_wheelbase,
  output cke_pkg::front_t     front
);
  import cke_pkg::*;

  logic signed [49:0] la_prod, aa_prod;
  logic [31:0]        th_mag;
  logic signed [33:0] ms_s, ma_s;
  logic [46:0]        rem_diff;
  logic [13:0]        q_est;

  // Stage 1
  side_t              s1;
  logic signed [33:0] nv_raw, ns_raw;
  logic [31:0]        mag1;
  logic [45:0]        p1;
  logic               th_neg1;
  // Stage 2
  side_t              s2;
  logic [33:0]        rem2;
  logic               th_neg2;
  // Stage 3
  side_t              s3;
  logic signed [33:0] zh3;
  angle_t             as3;
  logic signed [63:0] w1_prod;
  // Stage 4
  side_t              s4;
  logic signed [33:0] zh4;
  angle_t             as4;
  // Stage 5
  side_t              s5;
  angle_t             ah5;
  angle_t             as5;

  always_comb begin
    la_prod = speed_rate * TIME_STEP_Q16;
    aa_prod = steer_rate * TIME_STEP_Q16;
    th_mag  = heading[31] ? (~heading + 32'd1) : heading;
    ms_s    = $signed({3'b000, max_speed});
    ma_s    = $signed({17'd0, max_steer});
    q_est   = p1[45:32];
    rem_diff = {1'b0, mag1, 14'd0} - (47'(q_est) * TWO_PI_U47);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: integrate, start the turn count estimate of the heading.
      s1.px     <= pos_x;
      s1.py     <= pos_y;
      s1.th     <= heading;
      s1.nv     <= '0;
      s1.ns     <= '0;
      s1.ok     <= 1'b0;
      s1.w1     <= '0;
      nv_raw    <= {{2{speed[31]}}, speed} + $signed(la_prod[49:16]);
      ns_raw    <= {{2{steer_angle[31]}}, steer_angle} + $signed(aa_prod[49:16]);
      mag1      <= th_mag;
      p1        <= th_mag * RECIP_TWO_PI;
      th_neg1   <= heading[31];

      // Stage 2: clamp; remainder after the estimated whole turns.
      s2.px     <= s1.px;
      s2.py     <= s1.py;
      s2.th     <= s1.th;
      s2.w1     <= s1.w1;
      s2.ok     <= (nv_raw <= ms_s) && (nv_raw >= -ms_s) &&
                   (ns_raw <= ma_s) && (ns_raw >= -ma_s);
      if (nv_raw > ms_s) s2.nv <= ms_s[31:0];
      else if (nv_raw < -ms_s) s2.nv <= 32'(-ms_s);
      else s2.nv <= nv_raw[31:0];
      if (ns_raw > ma_s) s2.ns <= ma_s[31:0];
      else if (ns_raw < -ma_s) s2.ns <= 32'(-ma_s);
      else s2.ns <= ns_raw[31:0];
      rem2      <= rem_diff[33:0];
      th_neg2   <= th_neg1;

      // Stage 3: the estimate may be one turn short. The clamped steering
      // angle is always below pi, so it needs only the half-turn fold.
      s3        <= s2;
      if (rem2 >= TWO_PI_U) begin
        zh3 <= th_neg2 ? -$signed(rem2 - TWO_PI_U) : $signed(rem2 - TWO_PI_U);
      end else begin
        zh3 <= th_neg2 ? -$signed(rem2) : $signed(rem2);
      end
      as3       <= half_reduce($signed({s2.ns[31], s2.ns[18:0], 14'd0}));
      w1_prod   <= s2.nv * $signed({1'b0, inv_wheelbase});

      // Stage 4: wrap the heading into [-pi, pi].
      s4.px     <= s3.px;
      s4.py     <= s3.py;
      s4.th     <= s3.th;
      s4.nv     <= s3.nv;
      s4.ns     <= s3.ns;
      s4.ok     <= s3.ok;
      s4.w1     <= sat32(w1_prod >>> 16);
      if (zh3 > Q30_PI) zh4 <= zh3 - Q30_TWO_PI;
      else if (zh3 < -Q30_PI) zh4 <= zh3 + Q30_TWO_PI;
      else zh4 <= zh3;
      as4       <= as3;

      // Stage 5: half-turn fold of the heading.
      s5        <= s4;
      ah5       <= half_reduce(zh4);
      as5       <= as4;
    end
  end

  assign front.side = s5;
  assign front.ah   = ah5;
  assign front.as   = as5;

endmodule
`default_nettype wire

// File: design/cke_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_cordic
// Rotation-mode CORDIC, one iteration per register stage, followed by one
// stage that applies the half-turn sign flip. Output in Q2.30.
// ----------------------------------------------------------------------------
module cke_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               en,
  input  cke_pkg::angle_t    ang,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);
  import cke_pkg::*;

  logic signed [33:0] x_r [0:STAGES-1];
  logic signed [33:0] y_r [0:STAGES-1];
  logic signed [33:0] z_r [0:STAGES-1];
  logic [STAGES-1:0]  flip_r;
  logic signed [33:0] x_neg, y_neg;

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [33:0] xi, yi, zi;
    logic               fi;
    if (i == 0) begin : g_first
      assign xi = Q30_GAIN;
      assign yi = '0;
      assign zi = ang.z;
      assign fi = ang.flip;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = flip_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (zi >= 0) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - atan_q30(5'(i));
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + atan_q30(5'(i));
        end
        flip_r[i] <= fi;
      end
    end
  end

  assign x_neg = -x_r[STAGES-1];
  assign y_neg = -y_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= flip_r[STAGES-1] ? x_neg[31:0] : x_r[STAGES-1][31:0];
      sin_out <= flip_r[STAGES-1] ? y_neg[31:0] : y_r[STAGES-1][31:0];
    end
  end

endmodule
`default_nettype wire

// File: design/cke_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_div
// Pipelined tangent: trunc(sin * 2^16 / cos), saturated to 32 bits. Restoring
// division on magnitudes, one quotient bit per stage; 33 stages in all.
// ----------------------------------------------------------------------------
module cke_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] sin_in,
  input  logic signed [31:0] cos_in,
  output logic signed [31:0] tan_out
);
  import cke_pkg::*;

  typedef struct packed {
    logic neg;
    logic s_pos;
    logic s_neg;
    logic czero;
    logic ovf;
  } div_flags_t;

  logic [31:0] s_mag, c_mag;
  logic [47:0] num0;
  div_flags_t  fl0;

  logic [47:0] rem_r [0:31];
  logic [31:0] den_r [0:31];
  logic [30:0] q_r   [0:31];
  div_flags_t  fl_r  [0:31];

  always_comb begin
    s_mag = sin_in[31] ? (~sin_in + 32'd1) : sin_in;
    c_mag = cos_in[31] ? (~cos_in + 32'd1) : cos_in;
    num0  = {s_mag, 16'd0};
    fl0.neg   = sin_in[31] ^ cos_in[31];
    fl0.s_pos = (sin_in > 0);
    fl0.s_neg = sin_in[31];
    fl0.czero = (cos_in == 0);
    // A quotient of 2^31 or more saturates.
    fl0.ovf   = {15'd0, num0} >= {c_mag, 31'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num0;
      den_r[0] <= c_mag;
      q_r[0]   <= '0;
      fl_r[0]  <= fl0;
    end
  end

  for (genvar j = 1; j < 32; j++) begin : g_bit
    localparam int K = 31 - j;
    logic [62:0] dsh, diff;
    logic        ge;
    logic [30:0] q_next;

    always_comb begin
      dsh    = {31'd0, den_r[j-1]} << K;
      diff   = {15'd0, rem_r[j-1]} - dsh;
      ge     = {15'd0, rem_r[j-1]} >= dsh;
      q_next = q_r[j-1];
      q_next[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? diff[47:0] : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= q_next;
        fl_r[j]  <= fl_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl_r[31].czero) begin
        if (fl_r[31].s_pos) tan_out <= S32_MAX;
        else if (fl_r[31].s_neg) tan_out <= -S32_MAX;
        else tan_out <= '0;
      end else if (fl_r[31].ovf) begin
        tan_out <= fl_r[31].neg ? S32_MIN : S32_MAX;
      end else begin
        tan_out <= fl_r[31].neg ? -$signed({1'b0, q_r[31]}) : $signed({1'b0, q_r[31]});
      end
    end
  end

endmodule
`default_nettype wire

// File: design/car_kinematic_euler_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// car_kinematic_euler_step
// One forward-Euler step of the kinematic car model in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_* transaction carries a pose and an acceleration pair; exactly one
//   m_* transaction follows with the stepped pose, clamped speed and steering,
//   and the admissible flag in m_tuser. Results leave in input order.
//   Configuration is written through cfg_we/cfg_index/cfg_data while the
//   block is idle; indexes beyond the register list are ignored.
//   From acceptance to m_tvalid a transaction passes 5 front stages, the
//   CORDIC iterations plus a sign stage, the 33-stage tangent divider, 4
//   back-end stages and the output register. The fully pipelined datapath
//   takes one transaction per cycle while the skid register is empty.
//   A skid register behind the output register absorbs one result when the
//   receiver stalls; s_tready falls only once that skid register is full, and
//   the whole pipeline then holds until the receiver takes a result.
//   Synchronous reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module car_kinematic_euler_step #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, heading, speed, steer_angle, speed_rate, steer_rate
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_pos_x, new_pos_y, new_heading, new_speed, new_steer
  output logic [159:0] m_tdata,
  // input_admissible
  output logic [0:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import cke_pkg::*;

  localparam int PIPE_LAT = FRONT_LAT + CORDIC_STAGES + 1 + DIV_LAT + BACK_LAT;

  logic [30:0] max_speed;
  logic [16:0] max_steer;
  logic [30:0] inv_wheelbase;

  logic                en;
  logic [PIPE_LAT-1:0] vpipe;
  front_t              front;
  side_t               side_c;
  mid_t                mid_i, mid_o;
  logic signed [31:0]  cos_h, sin_h, cos_s, sin_s, tn;

  // Back-end registers
  logic signed [63:0] e1_px_prod, e1_py_prod, e1_w_prod;
  side_t              e1_side, e2_side, e3_side;
  logic signed [33:0] e2_vx, e2_vy;
  logic signed [31:0] e2_w;
  logic signed [51:0] e3_vx_t, e3_vy_t;
  logic signed [49:0] e3_w_t;
  logic [159:0]       p_data;
  logic               p_user;

  // Output and skid registers
  logic [159:0] out_data, skid_data;
  logic         out_user, skid_user;
  logic         out_valid, skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed     <= MAX_SPEED_RST;
      max_steer     <= MAX_STEER_RST;
      inv_wheelbase <= INV_WHEELBASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SPEED:     max_speed     <= cfg_data;
        CFG_MAX_STEER:     max_steer     <= cfg_data[16:0];
        CFG_INV_WHEELBASE: inv_wheelbase <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (en) vpipe <= {vpipe[PIPE_LAT-2:0], s_tvalid};
  end

  cke_front u_front (
    .clk           (clk),
    .en            (en),
    .pos_x         (s_tdata[31:0]),
    .pos_y         (s_tdata[63:32]),
    .heading       (s_tdata[95:64]),
    .speed         (s_tdata[127:96]),
    .steer_angle   (s_tdata[159:128]),
    .speed_rate    (s_tdata[191:160]),
    .steer_rate    (s_tdata[223:192]),
    .max_speed     (max_speed),
    .max_steer     (max_steer),
    .inv_wheelbase (inv_wheelbase),
    .front         (front)
  );

  cke_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_head (
    .clk     (clk),
    .en      (en),
    .ang     (front.ah),
    .cos_out (cos_h),
    .sin_out (sin_h)
  );

  cke_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_steer (
    .clk     (clk),
    .en      (en),
    .ang     (front.as),
    .cos_out (cos_s),
    .sin_out (sin_s)
  );

  cke_delay #(.WIDTH($bits(side_t)), .DEPTH(CORDIC_STAGES + 1)) u_side_dly (
    .clk  (clk),
    .en   (en),
    .din  (front.side),
    .dout (side_c)
  );

  assign mid_i.side = side_c;
  assign mid_i.cv   = cos_h;
  assign mid_i.sv   = sin_h;

  cke_div u_div (
    .clk     (clk),
    .en      (en),
    .sin_in  (sin_s),
    .cos_in  (cos_s),
    .tan_out (tn)
  );

  cke_delay #(.WIDTH($bits(mid_t)), .DEPTH(DIV_LAT)) u_mid_dly (
    .clk  (clk),
    .en   (en),
    .din  (mid_i),
    .dout (mid_o)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      // Rates: speed times cos and sin, yaw rate from the tangent.
      e1_px_prod <= mid_o.side.nv * mid_o.cv;
      e1_py_prod <= mid_o.side.nv * mid_o.sv;
      e1_w_prod  <= mid_o.side.w1 * tn;
      e1_side    <= mid_o.side;

      e2_vx      <= e1_px_prod[63:30];
      e2_vy      <= e1_py_prod[63:30];
      e2_w       <= sat32(e1_w_prod >>> 16);
      e2_side    <= e1_side;

      e3_vx_t    <= e2_vx * TIME_STEP_Q16;
      e3_vy_t    <= e2_vy * TIME_STEP_Q16;
      e3_w_t     <= e2_w * TIME_STEP_Q16;
      e3_side    <= e2_side;

      p_data[31:0]    <= sat32({{32{e3_side.px[31]}}, e3_side.px} +
                               {{28{e3_vx_t[51]}}, e3_vx_t[51:16]});
      p_data[63:32]   <= sat32({{32{e3_side.py[31]}}, e3_side.py} +
                               {{28{e3_vy_t[51]}}, e3_vy_t[51:16]});
      p_data[95:64]   <= sat32({{32{e3_side.th[31]}}, e3_side.th} +
                               {{30{e3_w_t[49]}}, e3_w_t[49:16]});
      p_data[127:96]  <= e3_side.nv;
      p_data[159:128] <= e3_side.ns;
      p_user          <= e3_side.ok;
    end
  end

  // The last pipeline stage is drained into the output register, or into the
  // skid register when the output is still waiting for the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        out_data   <= skid_data;
        out_user   <= skid_user;
        skid_valid <= 1'b0;
      end
    end else if (vpipe[PIPE_LAT-1]) begin
      if (!out_valid || m_tready) begin
        out_data  <= p_data;
        out_user  <= p_user;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= p_data;
        skid_user  <= p_user;
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_data;
  assign m_tuser[0] = out_user;

endmodule
`default_nettype wire

// File: design/cke_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_checker
// Port-level checks of the car kinematic Euler step block, bound to its top.
// ----------------------------------------------------------------------------
module cke_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [159:0] m_tdata,
  input logic [0:0]   m_tuser
);

  // Reset empties the pipeline and opens the input.
  a_reset: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("block not empty after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // The input closes only with a result waiting at the output.
  a_closed_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input closed with empty output");

  // A taken transaction frees the skid register at once.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (!s_tready && m_tready) |=> s_tready)
    else $error("input stayed closed after result was taken");

  // The skid entry moves into the output register.
  a_skid_move: assert property (@(posedge clk) disable iff (rst)
    (!s_tready && m_tvalid && m_tready) |=> m_tvalid)
    else $error("buffered result lost");

endmodule

bind car_kinematic_euler_step cke_checker u_cke_checker (.*);
`default_nettype wire
